/* rtl/core/dqse_pkg.sv */
package dqse_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam logic [2:0] FUNC_PUSH_BACK  = 3'd0;
	localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
	localparam logic [2:0] FUNC_POP_BACK   = 3'd2;
	localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
	localparam logic [2:0] FUNC_FIND       = 3'd4;
	localparam logic [2:0] FUNC_ERASE      = 3'd5;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] key;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [4:0]         count;
		logic               is_empty;
	} result_word_t;

	// The offset must lie between zero and DEPTH.
	function automatic idx_t ring_add(idx_t base, cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

	function automatic idx_t ring_inc(idx_t p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic idx_t ring_dec(idx_t p);
		return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
	endfunction

endpackage

/* rtl/core/deque_with_search_and_erase_core.sv */
// Push, pop and unused codes pass through the read-front, read-back and capture states before the result.
// Find first walks the entries from the front in the search state, up to the first match or the last entry.
// Erase then moves each later entry one place forward in the shift state to close the gap.
// One item is in flight at a time; the next word can be taken in the cycle that shows the result.
// The receiver cannot stall: each result word is shown for exactly one cycle.
// Reset clears pointers and count at once; stored entries are not cleared.
module deque_with_search_and_erase_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  dqse_pkg::cmd_word_t    cmd,
	output logic                   done,
	output dqse_pkg::result_word_t result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_RD_FRONT,
		ST_RD_BACK,
		ST_CAPTURE
	} state_t;

	state_t                 state_q;
	dqse_pkg::idx_t         front_q;
	dqse_pkg::cnt_t         occ_q;
	dqse_pkg::cnt_t         idx_q;
	dqse_pkg::idx_t         rd_ptr_q;
	dqse_pkg::idx_t         wr_ptr_q;
	logic [2:0]             func_q;
	dqse_pkg::key_t         key_q;
	logic [1:0]             status_q;
	logic                   found_q;
	dqse_pkg::key_t         front_val_q;
	logic                   done_q;
	dqse_pkg::result_word_t result_q;

	logic                   accept;
	logic                   ram_we;
	dqse_pkg::idx_t         ram_waddr;
	dqse_pkg::key_t         ram_wdata;
	dqse_pkg::idx_t         ram_raddr;
	dqse_pkg::key_t         ram_rdata;
	dqse_pkg::key_t         cmd_key;
	logic                   full;
	logic                   empty;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign cmd_key = dqse_pkg::key_t'(cmd.key);
	assign full    = (occ_q == dqse_pkg::CNT_W'(dqse_pkg::DEPTH));
	assign empty   = (occ_q == '0);
	assign done    = done_q;
	assign result  = result_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_wdata = key_q;
		ram_raddr = front_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !full) begin
					if (cmd.func == dqse_pkg::FUNC_PUSH_BACK) begin
						ram_we    = 1'b1;
						ram_waddr = dqse_pkg::ring_add(front_q, occ_q);
						ram_wdata = cmd_key;
					end else if (cmd.func == dqse_pkg::FUNC_PUSH_FRONT) begin
						ram_we    = 1'b1;
						ram_waddr = dqse_pkg::ring_dec(front_q);
						ram_wdata = cmd_key;
					end
				end
			end
			ST_SEARCH: begin
				ram_raddr = dqse_pkg::ring_inc(rd_ptr_q);
			end
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = wr_ptr_q;
				ram_wdata = ram_rdata;
				ram_raddr = dqse_pkg::ring_inc(rd_ptr_q);
			end
			ST_RD_FRONT: begin
				ram_raddr = front_q;
			end
			ST_RD_BACK: begin
				ram_raddr = empty ? front_q : dqse_pkg::ring_add(front_q, occ_q - 1'b1);
			end
			ST_CAPTURE: begin
				ram_raddr = front_q;
			end
			default: begin
				ram_raddr = front_q;
			end
		endcase
	end

	dqse_ram #(
		.WIDTH(dqse_pkg::KEY_BITS),
		.DEPTH(dqse_pkg::DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			front_q  <= '0;
			occ_q    <= '0;
			idx_q    <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q   <= cmd.func;
						key_q    <= cmd_key;
						found_q  <= 1'b0;
						status_q <= dqse_pkg::STATUS_OK;
						state_q  <= ST_RD_FRONT;
						unique case (cmd.func)
							dqse_pkg::FUNC_PUSH_BACK: begin
								if (full) begin
									status_q <= dqse_pkg::STATUS_FULL;
								end else begin
									occ_q <= occ_q + 1'b1;
								end
							end
							dqse_pkg::FUNC_PUSH_FRONT: begin
								if (full) begin
									status_q <= dqse_pkg::STATUS_FULL;
								end else begin
									front_q <= dqse_pkg::ring_dec(front_q);
									occ_q   <= occ_q + 1'b1;
								end
							end
							dqse_pkg::FUNC_POP_BACK: begin
								if (empty) begin
									status_q <= dqse_pkg::STATUS_EMPTY;
								end else begin
									occ_q <= occ_q - 1'b1;
								end
							end
							dqse_pkg::FUNC_POP_FRONT: begin
								if (empty) begin
									status_q <= dqse_pkg::STATUS_EMPTY;
								end else begin
									front_q <= dqse_pkg::ring_inc(front_q);
									occ_q   <= occ_q - 1'b1;
								end
							end
							dqse_pkg::FUNC_FIND, dqse_pkg::FUNC_ERASE: begin
								if (empty) begin
									status_q <= dqse_pkg::STATUS_NOT_FOUND;
								end else begin
									rd_ptr_q <= front_q;
									idx_q    <= '0;
									state_q  <= ST_SEARCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (ram_rdata == key_q) begin
						found_q <= 1'b1;
						if (func_q == dqse_pkg::FUNC_ERASE) begin
							if ((idx_q + 1'b1) >= occ_q) begin
								occ_q   <= occ_q - 1'b1;
								state_q <= ST_RD_FRONT;
							end else begin
								wr_ptr_q <= rd_ptr_q;
								rd_ptr_q <= dqse_pkg::ring_inc(rd_ptr_q);
								state_q  <= ST_SHIFT;
							end
						end else begin
							state_q <= ST_RD_FRONT;
						end
					end else if ((idx_q + 1'b1) == occ_q) begin
						status_q <= dqse_pkg::STATUS_NOT_FOUND;
						state_q  <= ST_RD_FRONT;
					end else begin
						idx_q    <= idx_q + 1'b1;
						rd_ptr_q <= dqse_pkg::ring_inc(rd_ptr_q);
					end
				end
				ST_SHIFT: begin
					if (((dqse_pkg::CNT_W + 1)'(idx_q) + 2'd2) >= (dqse_pkg::CNT_W + 1)'(occ_q)) begin
						occ_q   <= occ_q - 1'b1;
						state_q <= ST_RD_FRONT;
					end else begin
						idx_q    <= idx_q + 1'b1;
						wr_ptr_q <= rd_ptr_q;
						rd_ptr_q <= dqse_pkg::ring_inc(rd_ptr_q);
					end
				end
				ST_RD_FRONT: begin
					state_q <= ST_RD_BACK;
				end
				ST_RD_BACK: begin
					front_val_q <= ram_rdata;
					state_q     <= ST_CAPTURE;
				end
				ST_CAPTURE: begin
					result_q.status      <= status_q;
					result_q.found       <= found_q;
					result_q.front_value <= empty ? '0 : 32'(front_val_q);
					result_q.back_value  <= empty ? '0 : 32'(ram_rdata);
					result_q.count       <= 5'(occ_q);
					result_q.is_empty    <= empty;
					done_q               <= 1'b1;
					state_q              <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= dqse_pkg::CNT_W'(dqse_pkg::DEPTH))
		else $error("Occupancy exceeds the ring depth.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result word shown while an operation is still running.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("Accepted word did not start an operation.");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found) |-> (result.status == dqse_pkg::STATUS_OK))
		else $error("A match was reported with a failing status.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == (result.count == 5'd0)))
		else $error("Empty flag disagrees with the count.");

endmodule

/* rtl/core/dqse_ram.sv */
module dqse_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* test/deque_with_search_and_erase_checker.sv */
module deque_with_search_and_erase_checker
	import dqse_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         busy,
	input  cmd_word_t    cmd,
	input  logic         done,
	input  result_word_t result,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	key_t         ring [DEPTH];
	int           head;
	int           occ;
	result_word_t awaited_results [$];
	result_word_t want;

	function automatic int slot(input int offset);
		return (head + offset) % DEPTH;
	endfunction

	function automatic result_word_t apply_deque_op(input cmd_word_t w);
		result_word_t r;
		key_t         k;
		int           hit;
		int           i;
		r = '0;
		k = key_t'(w.key);
		r.status = STATUS_OK;
		case (w.func)
			FUNC_PUSH_BACK: begin
				if (occ >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					ring[slot(occ)] = k;
					occ++;
				end
			end
			FUNC_PUSH_FRONT: begin
				if (occ >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					head = (head + DEPTH - 1) % DEPTH;
					ring[head] = k;
					occ++;
				end
			end
			FUNC_POP_BACK: begin
				if (occ == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					occ--;
				end
			end
			FUNC_POP_FRONT: begin
				if (occ == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					head = slot(1);
					occ--;
				end
			end
			FUNC_FIND, FUNC_ERASE: begin
				hit = -1;
				for (i = 0; i < occ; i++) begin
					if (hit < 0 && ring[slot(i)] == k) begin
						hit = i;
					end
				end
				if (hit < 0) begin
					r.status = STATUS_NOT_FOUND;
				end else begin
					r.found = 1'b1;
					if (w.func == FUNC_ERASE) begin
						for (i = hit; i + 1 < occ; i++) begin
							ring[slot(i)] = ring[slot(i + 1)];
						end
						occ--;
					end
				end
			end
			default: begin
			end
		endcase
		if (occ != 0) begin
			r.front_value = ring[slot(0)];
			r.back_value  = ring[slot(occ - 1)];
		end
		r.count    = 5'(occ);
		r.is_empty = (occ == 0);
		return r;
	endfunction

	function automatic string word_text(input result_word_t r);
		return $sformatf("status=%0d found=%0d front=%0d back=%0d count=%0d empty=%0d",
			r.status, r.found, r.front_value, r.back_value, r.count, r.is_empty);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			occ = 0;
			fail_count = 0;
			awaited_results.delete();
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: result word with none outstanding: %s",
							$realtime, word_text(result));
					end
				end else begin
					want = awaited_results[0];
					awaited_results.delete(0);
					if (result.status !== want.status || result.found !== want.found ||
						result.front_value !== want.front_value ||
						result.back_value !== want.back_value ||
						result.count !== want.count || result.is_empty !== want.is_empty) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch\n  expected %s\n  actual   %s",
								$realtime, word_text(want), word_text(result));
						end
					end
				end
			end
			if (start && !busy) begin
				awaited_results = {awaited_results, apply_deque_op(cmd)};
			end
		end
		pending = awaited_results.size();
	end

endmodule

/* test/deque_with_search_and_erase_core_test.sv */
module deque_with_search_and_erase_core_test;
	import dqse_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_SEARCH} mix_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         start;
	logic         busy;
	cmd_word_t    cmd;
	logic         done;
	result_word_t result;
	int           failures;
	int           pending;
	int           cycles = 0;

	logic signed [31:0] key_pool [8];

	deque_with_search_and_erase_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	deque_with_search_and_erase_checker watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.fail_count(failures),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int idle_draw();
		return $urandom_range(0, 10);
	endfunction

	function automatic logic signed [31:0] pick_key();
		if ($urandom_range(0, 1)) begin
			return key_pool[$urandom_range(0, 7)];
		end
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_func(input mix_t mix);
		int r;
		int push_lim;
		int pop_lim;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GROW: begin
				push_lim = 70;
				pop_lim = 80;
			end
			MIX_SHRINK: begin
				push_lim = 20;
				pop_lim = 75;
			end
			default: begin
				push_lim = 35;
				pop_lim = 50;
			end
		endcase
		if (r < push_lim) begin
			return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
		end else if (r < pop_lim) begin
			return $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
		end else if (r < 96) begin
			return $urandom_range(0, 1) ? FUNC_ERASE : FUNC_FIND;
		end
		return $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
	endfunction

	// The word stays on the bus until the edge that accepts it; start is left high.
	task automatic issue(input logic [2:0] f, input logic signed [31:0] k, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd.func <= f;
		cmd.key <= k;
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int   sent;
		int   len;
		int   n;
		bit   no_gaps;
		mix_t mix;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		key_pool[0] = KEY_MAX;
		key_pool[1] = KEY_MIN;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (n = 4; n < 8; n++) begin
			key_pool[n] = $urandom;
		end
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		issue(FUNC_POP_BACK, $urandom, idle_draw());
		issue(FUNC_POP_FRONT, $urandom, idle_draw());
		issue(FUNC_FIND, 32'sd0, idle_draw());
		issue(FUNC_ERASE, 32'sd5, idle_draw());
		issue(FUNC_SPARE_LO, $urandom, idle_draw());
		issue(FUNC_SPARE_HI, $urandom, idle_draw());
		issue(FUNC_PUSH_BACK, KEY_MAX, idle_draw());
		issue(FUNC_PUSH_FRONT, KEY_MIN, idle_draw());
		issue(FUNC_PUSH_BACK, 32'sd0, idle_draw());
		issue(FUNC_PUSH_FRONT, -32'sd1, idle_draw());
		issue(FUNC_PUSH_BACK, KEY_MAX, idle_draw());
		issue(FUNC_FIND, KEY_MAX, idle_draw());
		issue(FUNC_FIND, 32'sd12345, idle_draw());
		issue(FUNC_SPARE_LO, KEY_MAX, idle_draw());
		issue(FUNC_ERASE, -32'sd1, idle_draw());
		issue(FUNC_ERASE, KEY_MAX, idle_draw());
		issue(FUNC_ERASE, KEY_MAX, idle_draw());
		issue(FUNC_POP_FRONT, $urandom, idle_draw());
		issue(FUNC_POP_BACK, $urandom, idle_draw());
		issue(FUNC_PUSH_FRONT, 32'sd55, idle_draw());
		issue(FUNC_ERASE, 32'sd55, idle_draw());
		issue(FUNC_ERASE, 32'sd55, idle_draw());

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mix = mix_t'($urandom_range(0, 2));
			len = $urandom_range(20, 80);
			no_gaps = ($urandom_range(0, 3) == 0);
			key_pool[$urandom_range(4, 7)] = $urandom;
			for (n = 0; n < len; n++) begin
				issue(pick_func(mix), pick_key(), no_gaps ? 0 : idle_draw());
			end
			if (sent == 0 || $urandom_range(0, 3) == 0) begin
				drain();
			end
			sent += len;
		end

		drain();
		repeat (2 * DEPTH + 8) @(negedge clk);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/dqse_pkg.sv
rtl/core/dqse_ram.sv
rtl/core/deque_with_search_and_erase_core.sv
test/deque_with_search_and_erase_checker.sv
test/deque_with_search_and_erase_core_test.sv
